/* hw/rtl/lpsa_pkg.sv */
// Shared types, constants and lookup tables for the log-polar sample address unit.
// No dependencies; every other file of the block depends on this package.
package lpsa_pkg;

  // Parameter defaults
  localparam int COORD_BITS_DEF   = 12;
  localparam int INDEX_BITS_DEF   = 8;
  localparam int CORDIC_STEPS_DEF = 16;

  // Field and datapath widths
  localparam int IDX_W      = 8;   // width of the index fields on the input channel
  localparam int IDX_MAX_W  = 10;  // widest index the block handles
  localparam int N_W        = 10;  // integer part of the growth exponent
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CMAX_W     = 16;  // widest coordinate register
  localparam int FOVEA_W    = 8;
  localparam int PHASE_W    = 16;
  localparam int LOG_W      = 16;
  localparam int RAD_FRAC   = 12;
  localparam int TRIG_FRAC  = 16;
  localparam int EXP_STEPS  = 16;
  localparam int STEPS_PER_STAGE = 4;
  localparam int M_W        = 18;  // exp2 mantissa, Q1.16 plus headroom
  localparam int XY_W       = 20;  // CORDIC x and y, signed Q1.16 plus headroom
  localparam int Z_W        = 26;  // residual angle, signed Q0.24 turns plus headroom
  localparam int ATAN_W     = 22;
  localparam int CORDIC_GAIN = 39797;
  localparam int FIFO_DEPTH = 4;

  // Register reset values
  localparam logic [CMAX_W-1:0]  CENTER_X_RST   = 16'd64;
  localparam logic [CMAX_W-1:0]  CENTER_Y_RST   = 16'd64;
  localparam logic [FOVEA_W-1:0] FOVEA_RST      = 8'd16;
  localparam logic [PHASE_W-1:0] ANGLE_STEP_RST = 16'd1024;
  localparam logic [LOG_W-1:0]   LOG_GROWTH_RST = 16'd2731;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_FOVEA      = 3'd2,
    REG_ANGLE_STEP = 3'd3,
    REG_LOG_GROWTH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CMAX_W-1:0]  center_x;
    logic [CMAX_W-1:0]  center_y;
    logic [FOVEA_W-1:0] fovea;
    logic [PHASE_W-1:0] angle_step;
    logic [LOG_W-1:0]   log_growth;
  } cfg_t;

  // Classified job handed from the front end to the back end
  typedef struct packed {
    logic                 inner;
    logic [IDX_MAX_W-1:0] ring;
    logic [N_W-1:0]       n;
    logic [LOG_W-1:0]     f;
    logic [PHASE_W-1:0]   phase;
  } job_t;

  // State carried through the exp2 / CORDIC stages
  typedef struct packed {
    logic                   inner;
    logic [IDX_MAX_W-1:0]   ring;
    logic [N_W-1:0]         n;
    logic [LOG_W-1:0]       f;
    logic [M_W-1:0]         m;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   flip;
  } stg_t;

  // round(log2(1 + 2^-(i+1)) * 2^16)
  function automatic logic [LOG_W-1:0] log2_tab(input int i);
    logic [LOG_W-1:0] v;
    case (i)
      0:  v = 16'd38336;
      1:  v = 16'd21098;
      2:  v = 16'd11136;
      3:  v = 16'd5732;
      4:  v = 16'd2909;
      5:  v = 16'd1466;
      6:  v = 16'd736;
      7:  v = 16'd369;
      8:  v = 16'd184;
      9:  v = 16'd92;
      10: v = 16'd46;
      11: v = 16'd23;
      12: v = 16'd12;
      13: v = 16'd6;
      14: v = 16'd3;
      15: v = 16'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round(atan(2^-i) * 2^24 / (2*pi))
  function automatic logic [ATAN_W-1:0] atan_tab(input int i);
    logic [ATAN_W-1:0] v;
    case (i)
      0:  v = 22'd2097152;
      1:  v = 22'd1238021;
      2:  v = 22'd654136;
      3:  v = 22'd332050;
      4:  v = 22'd166669;
      5:  v = 22'd83416;
      6:  v = 22'd41718;
      7:  v = 22'd20860;
      8:  v = 22'd10430;
      9:  v = 22'd5215;
      10: v = 22'd2608;
      11: v = 22'd1304;
      12: v = 22'd652;
      13: v = 22'd326;
      14: v = 22'd163;
      15: v = 22'd81;
      16: v = 22'd41;
      17: v = 22'd20;
      18: v = 22'd10;
      19: v = 22'd5;
      20: v = 22'd3;
      21: v = 22'd1;
      22: v = 22'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/lpsa_if.sv */
// Valid/ready channel interfaces for the log-polar sample address unit.
// Depends on lpsa_pkg for field widths.
interface lpsa_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpsa_pkg::IDX_W-1:0]    ring_index;
  logic [lpsa_pkg::IDX_W-1:0]    angle_index;
  modport source (output valid, ring_index, angle_index, input ready);
  modport sink   (input valid, ring_index, angle_index, output ready);
endinterface

interface lpsa_out_if #(parameter int COORD_BITS = lpsa_pkg::COORD_BITS_DEF);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] source_column;
  logic [COORD_BITS-1:0] source_row;
  modport source (output valid, source_column, source_row, input ready);
  modport sink   (input valid, source_column, source_row, output ready);
endinterface

interface lpsa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lpsa_pkg::CFG_IDX_W-1:0]   index;
  logic [lpsa_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/log_polar_sample_address_unit.sv */
// Log-polar sample address unit: maps (ring, angle) to a source pixel address.
// Depends on lpsa_pkg, lpsa_if, lpsa_front, lpsa_fifo and lpsa_back.
//
// Takes one (ring_index, angle_index) transaction per cycle while the job
// queue has room and returns one (source_column, source_row) transaction per
// input, in order. Throughput is one item per clock when the output is not
// stalled. Jobs pass through the exp2/CORDIC pipeline, which runs four steps
// per stage, then the fovea product, radius, product and output registers.
// A four-entry job queue sits between the classifier and the pipeline, so
// input keeps flowing while the output is held, until the queue is full.
// Registers are written through the cfg_ch channel, which is always ready;
// write them only while no transaction is in flight.
module log_polar_sample_address_unit #(
  parameter int COORD_BITS   = lpsa_pkg::COORD_BITS_DEF,
  parameter int INDEX_BITS   = lpsa_pkg::INDEX_BITS_DEF,
  parameter int CORDIC_STEPS = lpsa_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lpsa_in_if.sink    in_ch,
  lpsa_out_if.source out_ch,
  lpsa_cfg_if.sink   cfg_ch
);
  import lpsa_pkg::*;

  localparam logic [CMAX_W-1:0] CMASK = CMAX_W'((1 << COORD_BITS) - 1);

  cfg_t cfg_r;

  // Register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x   <= CENTER_X_RST;
      cfg_r.center_y   <= CENTER_Y_RST;
      cfg_r.fovea      <= FOVEA_RST;
      cfg_r.angle_step <= ANGLE_STEP_RST;
      cfg_r.log_growth <= LOG_GROWTH_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_CENTER_X:   cfg_r.center_x   <= cfg_ch.data & CMASK;
        REG_CENTER_Y:   cfg_r.center_y   <= cfg_ch.data & CMASK;
        REG_FOVEA:      cfg_r.fovea      <= cfg_ch.data[FOVEA_W-1:0];
        REG_ANGLE_STEP: cfg_r.angle_step <= cfg_ch.data;
        REG_LOG_GROWTH: cfg_r.log_growth <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Front end and queue
  job_t front_job;
  job_t back_job;
  logic fifo_full;
  logic fifo_empty;
  logic fifo_push;
  logic fifo_pop;

  assign in_ch.ready = !fifo_full;
  assign fifo_push   = in_ch.valid && !fifo_full;

  lpsa_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .ring_index (in_ch.ring_index),
    .angle_index(in_ch.angle_index),
    .cfg        (cfg_r),
    .job        (front_job)
  );

  lpsa_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_data(front_job),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_data (back_job),
    .empty    (fifo_empty)
  );

  // Back end
  logic                  out_valid;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;

  lpsa_back #(
    .COORD_BITS  (COORD_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .job      (back_job),
    .job_valid(!fifo_empty),
    .job_pop  (fifo_pop),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .col      (col),
    .row      (row)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.source_column = col;
  assign out_ch.source_row    = row;

  // Checks
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_pop |-> !fifo_empty)
    else $error("job queue popped while empty");

  a_fovea_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_ch.valid && cfg_ch.index == REG_FOVEA) |=>
      cfg_r.fovea == $past(cfg_ch.data[FOVEA_W-1:0]))
    else $error("fovea register write lost");

  a_reset_quiet: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_ch.valid)
    else $error("result valid right after reset");

endmodule

/* hw/rtl/lpsa_front.sv */
// Front end: masks the indices, classifies the ring as fovea or log ring,
// forms the growth exponent and the phase. Depends on lpsa_pkg.
module lpsa_front #(
  parameter int INDEX_BITS = lpsa_pkg::INDEX_BITS_DEF
) (
  input  logic [lpsa_pkg::IDX_W-1:0] ring_index,
  input  logic [lpsa_pkg::IDX_W-1:0] angle_index,
  input  lpsa_pkg::cfg_t             cfg,
  output lpsa_pkg::job_t             job
);
  import lpsa_pkg::*;

  localparam logic [IDX_MAX_W-1:0] IDX_MASK = IDX_MAX_W'((1 << INDEX_BITS) - 1);
  localparam int EXPO_W = IDX_MAX_W + LOG_W;
  localparam int TURN_W = IDX_MAX_W + PHASE_W;

  logic [IDX_MAX_W-1:0] ring;
  logic [IDX_MAX_W-1:0] aidx;
  logic [IDX_MAX_W-1:0] ring_ofs;
  logic [EXPO_W-1:0]    expo;
  logic [TURN_W-1:0]    turn;

  // Classify and form exponent and phase
  always_comb begin
    ring = IDX_MAX_W'(ring_index) & IDX_MASK;
    aidx = IDX_MAX_W'(angle_index) & IDX_MASK;
    ring_ofs = ring - IDX_MAX_W'(cfg.fovea);
    expo = EXPO_W'(cfg.log_growth) * EXPO_W'(ring_ofs);
    turn = TURN_W'(aidx) * TURN_W'(cfg.angle_step);
    job.inner = ring < IDX_MAX_W'(cfg.fovea);
    job.ring  = ring;
    job.n     = expo[EXPO_W-1 -: N_W];
    job.f     = expo[LOG_W-1:0];
    job.phase = turn[PHASE_W-1:0];
  end

endmodule

/* hw/rtl/lpsa_fifo.sv */
// Short job queue between front end and back end.
// Depends on lpsa_pkg for the job type; DEPTH must be a power of two.
module lpsa_fifo #(
  parameter int DEPTH = lpsa_pkg::FIFO_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lpsa_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output lpsa_pkg::job_t pop_data,
  output logic           empty
);
  import lpsa_pkg::*;

  localparam int PW = $clog2(DEPTH);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r;
  logic [PW-1:0] rd_r;
  logic [PW:0]   cnt_r;

  assign full     = cnt_r == (PW+1)'(DEPTH);
  assign empty    = cnt_r == '0;
  assign pop_data = mem_r[rd_r];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

/* hw/rtl/lpsa_back.sv */
// Back end: pipelined exp2 and CORDIC, radius scaling, products and
// saturation into the output register. Depends on lpsa_pkg.
module lpsa_back #(
  parameter int COORD_BITS   = lpsa_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = lpsa_pkg::CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lpsa_pkg::cfg_t        cfg,
  input  lpsa_pkg::job_t        job,
  input  logic                  job_valid,
  output logic                  job_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] col,
  output logic [COORD_BITS-1:0] row
);
  import lpsa_pkg::*;

  localparam int MAX_STEPS = (CORDIC_STEPS > EXP_STEPS) ? CORDIC_STEPS : EXP_STEPS;
  localparam int NSTG   = (MAX_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int VLD_W  = NSTG + 4;
  localparam int BASE_W = FOVEA_W + M_W;
  localparam int R_W    = COORD_BITS + RAD_FRAC;
  localparam int WIDE_W = BASE_W + R_W;
  localparam int PROD_W = R_W + XY_W;
  localparam int Q_W    = COORD_BITS + 2;
  localparam int S_W    = COORD_BITS + 4;
  localparam logic [R_W-1:0] RMAX = {R_W{1'b1}};
  localparam logic signed [Z_W-1:0] QUARTER = Z_W'(1 << 22);
  localparam logic signed [Z_W-1:0] HALF    = Z_W'(1 << 23);
  localparam logic signed [S_W-1:0] TOP     = S_W'((1 << COORD_BITS) - 1);

  // Four exp2 steps and four CORDIC steps of one stage
  function automatic stg_t step4(input stg_t s, input int first);
    stg_t                   o;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [XY_W-1:0] nx;
    logic signed [XY_W-1:0] ny;
    logic signed [Z_W-1:0]  z;
    logic [LOG_W-1:0]       f;
    logic [M_W-1:0]         m;
    int                     ic;
    int                     ie;
    o = s;
    x = s.x;
    y = s.y;
    z = s.z;
    f = s.f;
    m = s.m;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      ic = first + j;
      ie = first + j + 1;
      if (ic < CORDIC_STEPS) begin
        if (z >= 0) begin
          nx = x - (y >>> ic);
          ny = y + (x >>> ic);
          z  = z - $signed(Z_W'(atan_tab(ic)));
        end else begin
          nx = x + (y >>> ic);
          ny = y - (x >>> ic);
          z  = z + $signed(Z_W'(atan_tab(ic)));
        end
        x = nx;
        y = ny;
      end
      if (ie <= EXP_STEPS) begin
        if (f >= log2_tab(ie - 1)) begin
          f = f - log2_tab(ie - 1);
          m = m + (m >> ie);
        end
      end
    end
    o.x = x;
    o.y = y;
    o.z = z;
    o.f = f;
    o.m = m;
    return o;
  endfunction

  logic             adv;
  logic [VLD_W-1:0] vld_r;

  // Whole back end moves when the output register can take a result
  assign adv       = !vld_r[VLD_W-1] || out_ready;
  assign job_pop   = adv && job_valid;
  assign out_valid = vld_r[VLD_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[VLD_W-2:0], job_valid};
  end

  // Fold the phase into [-1/4, 1/4) turn and seed the iterations
  stg_t stg_in [NSTG];
  stg_t stg_r  [NSTG];

  always_comb begin
    stg_t                  s0;
    logic signed [Z_W-1:0] z0;
    z0 = Z_W'($signed({job.phase, 8'd0}));
    s0.flip = 1'b0;
    if (z0 >= QUARTER) begin
      z0 = z0 - HALF;
      s0.flip = 1'b1;
    end else if (z0 < -QUARTER) begin
      z0 = z0 + HALF;
      s0.flip = 1'b1;
    end
    s0.inner = job.inner;
    s0.ring  = job.ring;
    s0.n     = job.n;
    s0.f     = job.f;
    s0.m     = M_W'(1 << LOG_W);
    s0.x     = XY_W'(CORDIC_GAIN);
    s0.y     = '0;
    s0.z     = z0;
    stg_in[0] = s0;
  end

  // Iteration stages
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    if (k > 0) begin : g_link
      assign stg_in[k] = stg_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) stg_r[k] <= step4(stg_in[k], STEPS_PER_STAGE * k);
    end
  end

  // Mantissa times fovea; undo the half-turn fold
  logic [BASE_W-1:0]      base_r;
  logic                   inner1_r;
  logic [IDX_MAX_W-1:0]   ring1_r;
  logic [N_W-1:0]         n1_r;
  logic signed [XY_W-1:0] x1_r;
  logic signed [XY_W-1:0] y1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      base_r   <= BASE_W'(cfg.fovea) * BASE_W'(stg_r[NSTG-1].m);
      inner1_r <= stg_r[NSTG-1].inner;
      ring1_r  <= stg_r[NSTG-1].ring;
      n1_r     <= stg_r[NSTG-1].n;
      x1_r     <= stg_r[NSTG-1].flip ? -stg_r[NSTG-1].x : stg_r[NSTG-1].x;
      y1_r     <= stg_r[NSTG-1].flip ? -stg_r[NSTG-1].y : stg_r[NSTG-1].y;
    end
  end

  // Radius in Q12.12 with saturation; split cos and sin into sign and magnitude
  logic [WIDE_W-1:0] wide;
  logic [R_W-1:0]    r_nxt;
  logic [R_W-1:0]    r2_r;
  logic [XY_W-1:0]   xm2_r;
  logic [XY_W-1:0]   ym2_r;
  logic              xs2_r;
  logic              ys2_r;

  always_comb begin
    wide = WIDE_W'(base_r) << n1_r;
    wide = wide >> (LOG_W - RAD_FRAC);
    if (inner1_r) r_nxt = R_W'(ring1_r) << RAD_FRAC;
    else if (base_r == '0) r_nxt = '0;
    else if (n1_r >= N_W'(R_W)) r_nxt = RMAX;
    else if (wide > WIDE_W'(RMAX)) r_nxt = RMAX;
    else r_nxt = wide[R_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_r  <= r_nxt;
      xs2_r <= x1_r < 0;
      ys2_r <= y1_r < 0;
      xm2_r <= (x1_r < 0) ? XY_W'(-x1_r) : XY_W'(x1_r);
      ym2_r <= (y1_r < 0) ? XY_W'(-y1_r) : XY_W'(y1_r);
    end
  end

  // Exact products r*|cos| and r*|sin|
  logic [PROD_W-1:0] px3_r;
  logic [PROD_W-1:0] py3_r;
  logic              xs3_r;
  logic              ys3_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      px3_r <= PROD_W'(r2_r) * PROD_W'(xm2_r);
      py3_r <= PROD_W'(r2_r) * PROD_W'(ym2_r);
      xs3_r <= xs2_r;
      ys3_r <= ys2_r;
    end
  end

  // Truncate toward zero, offset by the center, saturate
  logic [Q_W-1:0]        qx;
  logic [Q_W-1:0]        qy;
  logic signed [S_W-1:0] vx;
  logic signed [S_W-1:0] vy;
  logic [COORD_BITS-1:0] col_nxt;
  logic [COORD_BITS-1:0] row_nxt;
  logic [COORD_BITS-1:0] col_r;
  logic [COORD_BITS-1:0] row_r;

  always_comb begin
    qx = px3_r[RAD_FRAC + TRIG_FRAC +: Q_W];
    qy = py3_r[RAD_FRAC + TRIG_FRAC +: Q_W];
    vx = $signed(S_W'(cfg.center_x[COORD_BITS-1:0]));
    vy = $signed(S_W'(cfg.center_y[COORD_BITS-1:0]));
    vx = xs3_r ? vx - $signed(S_W'(qx)) : vx + $signed(S_W'(qx));
    vy = ys3_r ? vy + $signed(S_W'(qy)) : vy - $signed(S_W'(qy));
    if (vx < 0) col_nxt = '0;
    else if (vx > TOP) col_nxt = TOP[COORD_BITS-1:0];
    else col_nxt = vx[COORD_BITS-1:0];
    if (vy < 0) row_nxt = '0;
    else if (vy > TOP) row_nxt = TOP[COORD_BITS-1:0];
    else row_nxt = vy[COORD_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col = col_r;
  assign row = row_r;

endmodule

/* bench/log_polar_sample_address_unit_tb.sv */
// Testbench for the log-polar sample address unit: directed and random rings and angles
// checked against an in-bench fixed-point predictor. Depends on lpsa_pkg, lpsa_if and the DUT.
`timescale 1ns / 1ps

module log_polar_sample_address_unit_tb;
  import lpsa_pkg::*;

  localparam int COORD_W  = 12;
  localparam int IDXB     = 8;
  localparam int CSTEPS   = 16;
  localparam int WDOG_MAX = 20000;
  localparam int DRAIN    = 40;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } addr_t;

  logic clk;
  logic rst_n;

  lpsa_in_if  in_ch ();
  lpsa_out_if #(.COORD_BITS(COORD_W)) out_ch ();
  lpsa_cfg_if cfg_ch ();

  log_polar_sample_address_unit #(
    .COORD_BITS(COORD_W), .INDEX_BITS(IDXB), .CORDIC_STEPS(CSTEPS)
  ) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // Predictor copy of the register file
  logic [11:0] ctr_x, ctr_y;
  logic [7:0]  fovea;
  logic [15:0] ang_step, growth;

  addr_t addr_queue[$];
  int    fail_count;
  int    send_idle_pct, recv_idle_pct;
  int    hold_off;
  int    idle_cycles;

  localparam logic [15:0] EXP_TAB[16] = '{38336, 21098, 11136, 5732, 2909, 1466, 736,
    369, 184, 92, 46, 23, 12, 6, 3, 1};
  localparam longint ROT_TAB[16] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
    41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  function automatic longint ring_radius(input logic [7:0] ring);
    longint unsigned e, f, m, base, r, rmax;
    int n;
    rmax = (64'd1 << (COORD_W + 12)) - 1;
    if (ring < fovea) return longint'(ring) << 12;
    e = longint'(growth) * longint'(ring - fovea);
    n = int'(e >> 16);
    f = e & 16'hFFFF;
    m = 65536;
    for (int i = 1; i <= 16; i++) begin
      if (f >= EXP_TAB[i-1]) begin
        f -= EXP_TAB[i-1];
        m += m >> i;
      end
    end
    base = longint'(fovea) * m;
    if (base == 0) return 0;
    if (n >= COORD_W + 12) return rmax;
    r = (base << n) >> 4;
    return (r > rmax) ? rmax : r;
  endfunction

  function automatic longint scale_trunc(input longint r, input longint t);
    longint q;
    q = ((t < 0 ? -t : t) * r) >>> 28;
    return (t < 0) ? -q : q;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
    if (v < 0) return '0;
    if (v > (1 << COORD_W) - 1) return '1;
    return v[COORD_W-1:0];
  endfunction

  function automatic addr_t sample_address(input logic [7:0] ring, input logic [7:0] aidx);
    longint r, z, x, y, nx, ny;
    logic [15:0] ph;
    bit flip;
    addr_t a;
    r = ring_radius(ring);
    ph = aidx * ang_step;
    z = longint'(ph) << 8;
    flip = 0;
    if (z >= (1 << 23)) z -= (1 << 24);
    if (z >= (1 << 22)) begin
      z -= (1 << 23);
      flip = 1;
    end else if (z < -(1 << 22)) begin
      z += (1 << 23);
      flip = 1;
    end
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < CSTEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z -= ROT_TAB[i];
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z += ROT_TAB[i];
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    a.column = clamp_coord(longint'(ctr_x) + scale_trunc(r, x));
    a.row    = clamp_coord(longint'(ctr_y) - scale_trunc(r, y));
    return a;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stall, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result transaction against the oldest expected address
  always @(posedge clk) begin
    addr_t exp_addr;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (addr_queue.size() == 0) begin
        $error("unexpected result column=%0d row=%0d", out_ch.source_column,
               out_ch.source_row);
        fail_count++;
      end else begin
        exp_addr = addr_queue.pop_front();
        if (out_ch.source_column !== exp_addr.column) begin
          $error("source_column expected %0d actual %0d", exp_addr.column,
                 out_ch.source_column);
          fail_count++;
        end
        if (out_ch.source_row !== exp_addr.row) begin
          $error("source_row expected %0d actual %0d", exp_addr.row, out_ch.source_row);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one ring/angle transaction and record its expected address;
  // valid stays high so the next transaction can follow without a gap
  task automatic send_pixel(input logic [7:0] ring, input logic [7:0] aidx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.ring_index  <= ring;
    in_ch.angle_index <= aidx;
    do @(posedge clk); while (!in_ch.ready);
    addr_queue.push_back(sample_address(ring, aidx));
    @(negedge clk);
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_CENTER_X:   ctr_x = val[11:0];
      REG_CENTER_Y:   ctr_y = val[11:0];
      REG_FOVEA:      fovea = val[7:0];
      REG_ANGLE_STEP: ang_step = val;
      REG_LOG_GROWTH: growth = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Drop input valid, wait for every expected result, then let the pipeline settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    wait (addr_queue.size() == 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] cx, input logic [15:0] cy,
                            input logic [15:0] fv, input logic [15:0] st,
                            input logic [15:0] lg);
    drain_results();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_FOVEA, fv);
    write_reg(REG_ANGLE_STEP, st);
    write_reg(REG_LOG_GROWTH, lg);
    cfg_ch.valid <= 1'b0;
  endtask

  // Field extremes, every quadrant, inner/outer boundary, at reset settings; then saturation, zero fovea
  task automatic test_directed();
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd15, 8'd0);
    send_pixel(8'd16, 8'd16);
    send_pixel(8'd17, 8'd32);
    send_pixel(8'd40, 8'd48);
    send_pixel(8'd8, 8'd64);
    send_pixel(8'd63, 8'd127);
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd170, 8'd85);
    send_pixel(8'd85, 8'd170);
    // Out of range address: large radius saturates both sides
    set_config(16'd4095, 16'd0, 16'd255, 16'd8192, 16'd65535);
    for (int a = 0; a < 8; a++) send_pixel(8'd255, 8'(a));
    // Zero fovea: every ring lands on the center
    set_config(16'd2000, 16'd3000, 16'd0, 16'd65535, 16'd40000);
    send_pixel(8'd0, 8'd1);
    send_pixel(8'd200, 8'd77);
    send_pixel(8'd255, 8'd255);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  task automatic test_config_sweep();
    set_config(16'd0, 16'd4095, 16'd1, 16'd0, 16'd0);
    test_random(40);
    set_config(16'($urandom), 16'($urandom), 16'($urandom_range(1, 255)),
               16'($urandom), 16'($urandom_range(0, 3000)));
    test_random(60);
    set_config(16'd2048, 16'd2048, 16'd32, 16'd257, 16'd1500);
    test_random(60);
  endtask

  // Stall output for a long stretch while input keeps offering
  task automatic test_backpressure();
    drain_results();
    hold_off = 200;
    send_idle_pct = 0;
    test_random(40);
  endtask

  initial begin
    rst_n = 0;
    fail_count = 0;
    hold_off = 0;
    idle_cycles = 0;
    send_idle_pct = 29;
    recv_idle_pct = 57;
    in_ch.valid = 0;
    in_ch.ring_index = '0;
    in_ch.angle_index = '0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = REG_CENTER_X;
    cfg_ch.data = '0;
    ctr_x = CENTER_X_RST[11:0];
    ctr_y = CENTER_Y_RST[11:0];
    fovea = FOVEA_RST;
    ang_step = ANGLE_STEP_RST;
    growth = LOG_GROWTH_RST;
    repeat (12) @(negedge clk);
    rst_n = 1;

    test_directed();
    set_config(16'd64, 16'd64, 16'd16, 16'd1024, 16'd2731);
    test_random(80);
    test_config_sweep();
    send_idle_pct = 57;
    recv_idle_pct = 29;
    set_config(16'd1000, 16'd500, 16'd8, 16'd12345, 16'd5000);
    test_random(120);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(16'd64, 16'd64, 16'd16, 16'd1024, 16'd2731);
    test_random(110);

    drain_results();
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lpsa_pkg.sv
hw/rtl/lpsa_if.sv
hw/rtl/lpsa_front.sv
hw/rtl/lpsa_fifo.sv
hw/rtl/lpsa_back.sv
hw/rtl/log_polar_sample_address_unit.sv
bench/log_polar_sample_address_unit_tb.sv
